// ===== rtl/core/lea128_block_cipher_top_defines.svh =====
// assertion macros shared by the checker
`ifndef LEA128_BLOCK_CIPHER_TOP_DEFINES_SVH
`define LEA128_BLOCK_CIPHER_TOP_DEFINES_SVH

// clocked check, off while in reset
`define LEA128_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers reset cycles
`define LEA128_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lea128_pkg.sv =====
`default_nettype none

package lea128_pkg;

  localparam int ROUNDS    = 24;
  localparam int RND_W     = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 64;
  localparam int CFG_IDX_W = 8;

  typedef logic [RND_W-1:0]         rnd_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef logic [3:0][WORD_W-1:0]   quad_t;

  localparam rnd_t LAST_RND = rnd_t'(ROUNDS - 1);

  localparam word_t DELTA [4] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 8'd0,
    REG_KEY_WORD_1 = 8'd1,
    REG_KEY_WORD_2 = 8'd2,
    REG_KEY_WORD_3 = 8'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_PRIME,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic  en;
    rnd_t  addr;
    quad_t data;
  } rk_wr_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } ks_stat_t;

  function automatic word_t rotl(word_t w, logic [4:0] r);
    logic [2*WORD_W-1:0] d;
    d = {w, w} << r;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr(word_t w, logic [4:0] r);
    logic [2*WORD_W-1:0] d;
    d = {w, w} >> r;
    return d[WORD_W-1:0];
  endfunction

  function automatic quad_t fwd_round(quad_t x, quad_t k);
    quad_t y;
    y[0] = rotl((x[0] ^ k[0]) + (x[1] ^ k[1]), 5'd9);
    y[1] = rotr((x[1] ^ k[2]) + (x[2] ^ k[1]), 5'd5);
    y[2] = rotr((x[2] ^ k[3]) + (x[3] ^ k[1]), 5'd3);
    y[3] = x[0];
    return y;
  endfunction

  function automatic quad_t inv_round(quad_t y, quad_t k);
    quad_t x;
    x[0] = y[3];
    x[1] = (rotr(y[0], 5'd9) - (x[0] ^ k[0])) ^ k[1];
    x[2] = (rotl(y[1], 5'd5) - (x[1] ^ k[2])) ^ k[1];
    x[3] = (rotl(y[2], 5'd3) - (x[2] ^ k[3])) ^ k[1];
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lea128_if.sv =====
`default_nettype none

interface lea128_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lea128_pkg::CFG_IDX_W-1:0]    index;
  logic [lea128_pkg::WORD_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface lea128_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [lea128_pkg::HALF_W-1:0]    block_low;
  logic [lea128_pkg::HALF_W-1:0]    block_high;

  modport source (output valid, output action, output block_low, output block_high,
                  input ready);
  modport sink   (input valid, input action, input block_low, input block_high,
                  output ready);
endinterface

interface lea128_out_if;
  logic                             valid;
  logic                             ready;
  logic [lea128_pkg::HALF_W-1:0]    result_low;
  logic [lea128_pkg::HALF_W-1:0]    result_high;

  modport source (output valid, output result_low, output result_high, input ready);
  modport sink   (input valid, input result_low, input result_high, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lea128_rk_store.sv =====
`default_nettype none

module lea128_rk_store (
  input  logic               clk,
  input  lea128_pkg::rk_wr_t wr,
  input  lea128_pkg::rnd_t   rd_addr,
  output lea128_pkg::quad_t  rd_data
);
  import lea128_pkg::*;

  quad_t mem [ROUNDS];
  quad_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/lea128_key_sched.sv =====
`default_nettype none

module lea128_key_sched (
  input  logic                 clk,
  input  logic                 rst_n,
  lea128_cfg_if.sink           cfg_ch,
  input  logic                 start,
  output lea128_pkg::ks_stat_t stat,
  output lea128_pkg::rk_wr_t   rk_wr
);
  import lea128_pkg::*;

  quad_t key_r;
  quad_t t_r, t_nxt;
  rnd_t  cnt_r;
  logic  busy_r;
  logic  ready_r;
  word_t dsel;
  logic  [4:0] amt;
  logic  cfg_beat;

  assign cfg_ch.ready = 1'b1;
  assign cfg_beat     = cfg_ch.valid && cfg_ch.ready;

  // delta rotated by the round number plus lane
  always_comb begin
    dsel = DELTA[2'(cnt_r)];
    amt  = 5'(cnt_r);
    t_nxt[0] = rotl(t_r[0] + rotl(dsel, amt),         5'd1);
    t_nxt[1] = rotl(t_r[1] + rotl(dsel, amt + 5'd1),  5'd3);
    t_nxt[2] = rotl(t_r[2] + rotl(dsel, amt + 5'd2),  5'd6);
    t_nxt[3] = rotl(t_r[3] + rotl(dsel, amt + 5'd3),  5'd11);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      busy_r  <= 1'b0;
      ready_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_beat) begin
        case (cfg_ch.index)
          REG_KEY_WORD_0: key_r[0] <= cfg_ch.data;
          REG_KEY_WORD_1: key_r[1] <= cfg_ch.data;
          REG_KEY_WORD_2: key_r[2] <= cfg_ch.data;
          REG_KEY_WORD_3: key_r[3] <= cfg_ch.data;
          default: ;
        endcase
        ready_r <= (cfg_ch.index inside {REG_KEY_WORD_0, REG_KEY_WORD_1,
                                         REG_KEY_WORD_2, REG_KEY_WORD_3})
                   ? 1'b0 : ready_r;
      end else if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + rnd_t'(1);
        if (cnt_r == LAST_RND) begin
          busy_r  <= 1'b0;
          ready_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r <= key_r;
    end else if (busy_r) begin
      t_r <= t_nxt;
    end
  end

  assign rk_wr.en   = busy_r;
  assign rk_wr.addr = cnt_r;
  assign rk_wr.data = t_nxt;

  assign stat.busy  = busy_r;
  assign stat.ready = ready_r;

endmodule

`default_nettype wire

// ===== rtl/core/lea128_core.sv =====
`default_nettype none

module lea128_core (
  input  logic                 clk,
  input  logic                 rst_n,
  lea128_in_if.sink            in_ch,
  lea128_out_if.source         out_ch,
  input  lea128_pkg::ks_stat_t ks_stat,
  output logic                 ks_start,
  output lea128_pkg::rnd_t     rd_addr,
  input  lea128_pkg::quad_t    rd_data
);
  import lea128_pkg::*;

  state_t state_r, state_nxt;
  rnd_t   cnt_r, cnt_nxt;
  rnd_t   kaddr_r, kaddr_nxt;
  logic   dec_r, dec_nxt;
  quad_t  blk_r, blk_nxt;
  quad_t  res_r, res_nxt;
  quad_t  rnd_out;
  logic   out_valid_r, out_valid_nxt;
  logic   in_beat;
  logic   slot_free;
  logic   out_load;
  logic   last_rnd;

  assign in_beat   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_rnd  = (cnt_r == LAST_RND);
  assign rnd_out   = dec_r ? inv_round(blk_r, rd_data) : fwd_round(blk_r, rd_data);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          state_nxt = ks_stat.ready ? ST_RUN : ST_KEYGEN;
        end
      end
      ST_KEYGEN: begin
        if (ks_stat.ready && !ks_stat.busy) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: state_nxt = ST_RUN;
      ST_RUN: begin
        if (last_rnd) begin
          state_nxt = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    ks_start    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ks_start    = in_ch.valid && !ks_stat.ready;
      end
      ST_RUN:  out_load = last_rnd && slot_free;
      ST_HOLD: out_load = slot_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt   = cnt_r;
    kaddr_nxt = kaddr_r;
    dec_nxt   = dec_r;
    blk_nxt   = blk_r;
    res_nxt   = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          blk_nxt   = {in_ch.block_high, in_ch.block_low};
          dec_nxt   = in_ch.action;
          cnt_nxt   = '0;
          kaddr_nxt = in_ch.action ? LAST_RND : '0;
        end
      end
      ST_PRIME: kaddr_nxt = dec_r ? LAST_RND : '0;
      ST_RUN: begin
        blk_nxt   = rnd_out;
        cnt_nxt   = cnt_r + rnd_t'(1);
        kaddr_nxt = dec_r ? kaddr_r - rnd_t'(1) : kaddr_r + rnd_t'(1);
        res_nxt   = rnd_out;
      end
      ST_HOLD: res_nxt = blk_r;
      default: ;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  assign rd_addr = kaddr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      kaddr_r     <= '0;
      dec_r       <= 1'b0;
      blk_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      kaddr_r     <= kaddr_nxt;
      dec_r       <= dec_nxt;
      blk_r       <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_low  = {res_r[1], res_r[0]};
  assign out_ch.result_high = {res_r[3], res_r[2]};

endmodule

`default_nettype wire

// ===== rtl/core/lea128_block_cipher_top.sv =====
`default_nettype none

// LEA-128 block cipher, one 128-bit block per input beat and one result beat per
// block. From accept to result a block spends the accept cycle, which with the round
// keys ready also issues the first round key read, then 24 rounds at one round per
// cycle, each round using the key row read from the 24 x 128-bit round key memory in
// the cycle before. The input is ready again in the cycle after the result is
// registered, so a new block is accepted only after the last one is through. After
// reset or any key word write the next block first waits for the key expansion,
// which writes one memory row per cycle while no config write arrives; the core then
// sees the expansion done and reads the first round key. Key words may only be written
// while no block is in flight; the config port is always ready. A finished result
// waits in the output register, and the next block may be accepted meanwhile.
module lea128_block_cipher_top (
  input  logic          clk,
  input  logic          rst_n,
  lea128_cfg_if.sink    cfg_ch,
  lea128_in_if.sink     in_ch,
  lea128_out_if.source  out_ch
);
  import lea128_pkg::*;

  ks_stat_t ks_stat;
  rk_wr_t   rk_wr;
  logic     ks_start;
  rnd_t     rd_addr;
  quad_t    rd_data;

  lea128_key_sched u_key_sched (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .start  (ks_start),
    .stat   (ks_stat),
    .rk_wr  (rk_wr)
  );

  lea128_rk_store u_rk_store (
    .clk     (clk),
    .wr      (rk_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lea128_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .ks_stat  (ks_stat),
    .ks_start (ks_start),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lea128_checker.sv =====
`default_nettype none

`include "lea128_block_cipher_top_defines.svh"

module lea128_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lea128_pkg::HALF_W-1:0] out_result_low
);
  import lea128_pkg::*;

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // result beat holds while stalled
  `LEA128_ASSERT(a_out_hold, out_stall |=> out_valid, "result beat dropped while stalled")
  `LEA128_ASSERT(a_out_stable, out_stall |=> $stable(out_result_low), "stalled result changed")
  // one block in flight at a time
  `LEA128_ASSERT(a_busy_after_beat, in_beat |=> !in_ready, "input ready right after a beat")
  // a new result appears only as the block finishes and input reopens
  `LEA128_ASSERT(a_result_reopens, $rose(out_valid) |-> in_ready, "result without input reopening")
  `LEA128_ASSERT_RST(a_reset_state, !rst_n |=> (!out_valid && in_ready), "bad state after reset")

endmodule

bind lea128_block_cipher_top lea128_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_result_low (out_ch.result_low)
);

`default_nettype wire

// ===== verif/lea128_block_cipher_top_test.sv =====
`default_nettype none

module lea128_block_cipher_top_test;
  import lea128_pkg::*;

  localparam int NUM_ROUNDS = 24;
  localparam int NUM_KEY_WORDS = 4;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int MAX_REPORTS = 10;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 8'hff;

  localparam logic [31:0] KS_DELTA [4] = '{
    32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
  };

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef enum logic {ROW_BLOCK, ROW_KEY} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [31:0]            val;
    logic                   act;
    logic [63:0]            lo;
    logic [63:0]            hi;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT, '1, '1},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT, '1, '1},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT,
      64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT,
      64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
    '{ROW_KEY, REG_KEY_WORD_0, 32'hffffffff, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_1, 32'hffffffff, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_2, 32'hffffffff, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_3, 32'hffffffff, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT, '1, '1},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_0, 32'h3c2d1e0f, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_1, 32'h78695a4b, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_2, 32'hb4a59687, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_KEY_WORD_3, 32'hf0e1d2c3, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT,
      64'h1716151413121110, 64'h1f1e1d1c1b1a1918},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT,
      64'h18c6c628354ec89f, 64'hfd8b6404a7c73255},
    '{ROW_KEY, REG_NONE_LO, 32'hffffffff, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_KEY, REG_NONE_HI, 32'h00000000, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT,
      64'h0123456789abcdef, 64'hfedcba9876543210},
    '{ROW_KEY, REG_KEY_WORD_2, 32'h00000001, ACT_ENCRYPT, 64'h0, 64'h0},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_DECRYPT,
      64'h0123456789abcdef, 64'hfedcba9876543210},
    '{ROW_BLOCK, REG_KEY_WORD_0, 32'h0, ACT_ENCRYPT,
      64'h8000000000000001, 64'h0000000180000000}
  };

  logic clk = 1'b0;
  logic rst_n;

  lea128_cfg_if cfg_ch ();
  lea128_in_if  in_ch ();
  lea128_out_if out_ch ();

  lea128_block_cipher_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  logic [31:0] key_words [NUM_KEY_WORDS];
  logic [31:0] round_keys [NUM_ROUNDS][4];
  bit          keys_valid;
  block_t      due_blocks [$];
  block_t      last_out;
  logic        last_act;
  bit          have_last;
  int          mismatches;
  int          cycles;
  int          src_pct;
  int          snk_pct;

  function automatic logic [31:0] rol32(logic [31:0] w, int unsigned r);
    r = r % 32;
    if (r == 0) return w;
    return (w << r) | (w >> (32 - r));
  endfunction

  function automatic logic [31:0] ror32(logic [31:0] w, int unsigned r);
    r = r % 32;
    if (r == 0) return w;
    return (w >> r) | (w << (32 - r));
  endfunction

  function automatic void expand_round_keys();
    logic [31:0] t [4];
    logic [31:0] d;
    for (int i = 0; i < NUM_KEY_WORDS; i++) t[i] = key_words[i];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      d = KS_DELTA[r % 4];
      t[0] = rol32(t[0] + rol32(d, r), 1);
      t[1] = rol32(t[1] + rol32(d, r + 1), 3);
      t[2] = rol32(t[2] + rol32(d, r + 2), 6);
      t[3] = rol32(t[3] + rol32(d, r + 3), 11);
      for (int i = 0; i < 4; i++) round_keys[r][i] = t[i];
    end
    keys_valid = 1'b1;
  endfunction

  function automatic block_t run_cipher(logic act, block_t blk);
    logic [3:0][31:0] x;
    logic [31:0] a, b, c, d;
    x = blk;
    if (act == ACT_ENCRYPT) begin
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        a = rol32((x[0] ^ round_keys[r][0]) + (x[1] ^ round_keys[r][1]), 9);
        b = ror32((x[1] ^ round_keys[r][2]) + (x[2] ^ round_keys[r][1]), 5);
        c = ror32((x[2] ^ round_keys[r][3]) + (x[3] ^ round_keys[r][1]), 3);
        x = {x[0], c, b, a};
      end
    end else begin
      for (int r = NUM_ROUNDS - 1; r >= 0; r--) begin
        a = x[3];
        b = (ror32(x[0], 9) - (a ^ round_keys[r][0])) ^ round_keys[r][1];
        c = (rol32(x[1], 5) - (b ^ round_keys[r][2])) ^ round_keys[r][1];
        d = (rol32(x[2], 3) - (c ^ round_keys[r][3])) ^ round_keys[r][1];
        x = {d, c, b, a};
      end
    end
    return x;
  endfunction

  function automatic logic [63:0] rand_half();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic log_miss(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // all tasks below start and end at a falling edge
  task automatic push_block(input logic act, input block_t blk);
    while ($urandom_range(99) < src_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.action     = act;
    in_ch.block_low  = blk.lo;
    in_ch.block_high = blk.hi;
    do @(posedge clk); while (!in_ch.ready);
    if (!keys_valid) expand_round_keys();
    last_out  = run_cipher(act, blk);
    last_act  = act;
    have_last = 1'b1;
    due_blocks.push_back(last_out);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (due_blocks.size() != 0) @(negedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < NUM_KEY_WORDS) begin
      key_words[idx[1:0]] = val;
      keys_valid = 1'b0;
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // fill 0: all zero, 1: all ones, else random and possibly partial
  task automatic rekey(input int fill);
    logic [31:0] w;
    drain_results();
    for (int i = 0; i < NUM_KEY_WORDS; i++) begin
      case (fill)
        0: w = '0;
        1: w = '1;
        default: w = ($urandom_range(9) == 0) ? '1 : $urandom;
      endcase
      if (fill < 2 || i == 0 || $urandom_range(3) != 0)
        write_key_reg(CFG_IDX_W'(i), w);
    end
    if ($urandom_range(7) == 0)
      write_key_reg($urandom_range(1) ? REG_NONE_HI : REG_NONE_LO, $urandom);
  endtask

  task automatic random_block();
    logic   act;
    block_t blk;
    if (have_last && $urandom_range(4) == 0) begin
      act = ~last_act;
      blk = last_out;
    end else begin
      act    = 1'($urandom_range(1));
      blk.lo = rand_half();
      blk.hi = rand_half();
    end
    push_block(act, blk);
  endtask

  always begin
    out_ch.ready = ($urandom_range(99) >= snk_pct);
    @(negedge clk);
  end

  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_blocks.size() == 0) begin
        log_miss($sformatf("result beat with nothing due: low %h high %h",
                           out_ch.result_low, out_ch.result_high));
      end else begin
        want = due_blocks.pop_front();
        if (out_ch.result_low !== want.lo)
          log_miss($sformatf("result_low: expected %h got %h", want.lo, out_ch.result_low));
        if (out_ch.result_high !== want.hi)
          log_miss($sformatf("result_high: expected %h got %h", want.hi, out_ch.result_high));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_ENCRYPT;
    in_ch.block_low  = '0;
    in_ch.block_high = '0;
    for (int i = 0; i < NUM_KEY_WORDS; i++) key_words[i] = '0;
    keys_valid = 1'b0;
    have_last  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_KEY) begin
        drain_results();
        write_key_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
      end else begin
        push_block(DIR_ROWS[i].act, '{hi: DIR_ROWS[i].hi, lo: DIR_ROWS[i].lo});
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      src_pct = (ph == 1) ? 66 : (ph == 3) ? 33 : 0;
      snk_pct = (ph == 2) ? 66 : (ph == 3) ? 33 : 0;
      rekey((ph == 0) ? 0 : (ph == 3) ? 1 : 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n > 0 && $urandom_range(59) == 0) rekey(2);
        random_block();
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && due_blocks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
